>>> rtl/podo_pkg.sv
// Shared types and constants for the planar odometry integrator.
// No dependencies.
package podo_pkg;

    localparam int MAX_STEPS = 24;

    localparam logic [31:0] CORDIC_X0 = 32'd652032874;
    localparam logic [31:0] INV_TWO_PI = 32'd683565276;
    localparam logic [15:0] TIME_STEP_RST = 16'd16777;
    localparam logic [15:0] GAIN_RST = 16'd18022;

    typedef enum logic [0:0] {
        REG_TIME_STEP = 1'b0,
        REG_GAIN      = 1'b1
    } reg_index_t;

    typedef enum logic [0:0] {
        OP_INTEGRATE = 1'b0,
        OP_LOAD      = 1'b1
    } op_t;

    // Rounded binary-angle arctangents, Q0.32 turns.
    function automatic logic [29:0] atan_lut(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/podo_if.sv
// Valid/ready channel interfaces for the odometry integrator.
// Depends on nothing; payload widths are fixed by the item fields.
interface podo_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] vel_x;
    logic [15:0] vel_y;
    logic [15:0] yaw_rate;
    logic [31:0] load_x;
    logic [31:0] load_y;
    logic [31:0] load_heading;
    modport source (output valid, op, vel_x, vel_y, yaw_rate, load_x, load_y, load_heading,
                    input ready);
    modport sink (input valid, op, vel_x, vel_y, yaw_rate, load_x, load_y, load_heading,
                  output ready);
endinterface

interface podo_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] heading;
    logic        saturated;
    modport source (output valid, pos_x, pos_y, heading, saturated, input ready);
    modport sink (input valid, pos_x, pos_y, heading, saturated, output ready);
endinterface

interface podo_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/planar_odometry_integrator.sv
// Planar odometry integrator top level. Uses podo_pkg and podo_if.
// A load result is registered and valid in the cycle after its transfer; an
// integrate tick commits after the CORDIC rotate, the product, a bit-serial
// multiply by time_step and one by odometry_gain, and the sum. A new tick is
// taken only after the last commits; input held while a result waits.
// Reset: pose zero, time_step 16777, odometry_gain 18022, output empty.
module planar_odometry_integrator #(
    parameter int ANGLE_BITS   = 32,
    parameter int CORDIC_STEPS = 16
) (
    input  logic clk,
    input  logic rst_n,
    podo_in_if.sink    in_ch,
    podo_out_if.source out_ch,
    podo_cfg_if.sink   cfg
);

    localparam int NSTEPS = (CORDIC_STEPS < podo_pkg::MAX_STEPS) ?
                            CORDIC_STEPS : podo_pkg::MAX_STEPS;
    localparam int CW = $clog2(NSTEPS + 1);
    localparam logic [31:0] ANGLE_MASK =
        32'hFFFF_FFFF << (32 - ANGLE_BITS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ROT   = 5'b00010,
        S_PROD  = 5'b00100,
        S_SER   = 5'b01000,
        S_SUM   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] time_step_reg, gain_reg;
    logic [31:0] pose_x_reg, pose_y_reg, pose_h_reg;

    // operand capture
    logic signed [15:0] vx_reg, vy_reg, wz_reg;

    // CORDIC datapath
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [31:0] cz_reg;
    logic [1:0]         quad_reg;
    logic [CW-1:0]      cnt_reg;

    // rotated products, scale 2^-38
    logic signed [50:0] rx_reg, ry_reg;
    logic signed [47:0] wprod_reg;

    // bit-serial accumulators
    logic [15:0]        ts_sh_reg, g_sh_reg;
    logic signed [67:0] tx_acc_reg, ty_acc_reg;
    logic signed [66:0] gx_acc_reg, gy_acc_reg;
    logic signed [35:0] tx_reg, ty_reg;
    logic [4:0]         bit_reg;
    logic               phase_reg;
    logic signed [65:0] th_acc_reg;

    logic        out_valid_reg;
    logic [31:0] out_x_reg, out_y_reg, out_h_reg;
    logic        out_sat_reg;

    logic in_xfer, out_free;
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE) && out_free;
    assign in_xfer   = in_ch.valid && in_ch.ready;
    assign cfg.ready = 1'b1;

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.pos_x     = out_x_reg;
    assign out_ch.pos_y     = out_y_reg;
    assign out_ch.heading   = out_h_reg;
    assign out_ch.saturated = out_sat_reg;

    // CORDIC iteration
    logic signed [33:0] sx, sy, cx_n, cy_n;
    logic signed [31:0] cz_n, at;
    logic [4:0] idx;
    always_comb
    begin
        idx  = 5'(cnt_reg);
        sx   = cx_reg >>> cnt_reg;
        sy   = cy_reg >>> cnt_reg;
        at   = 32'(podo_pkg::atan_lut(idx));
        if (!cz_reg[31])
        begin
            cx_n = cx_reg - sy;
            cy_n = cy_reg + sx;
            cz_n = cz_reg - at;
        end
        else
        begin
            cx_n = cx_reg + sy;
            cy_n = cy_reg - sx;
            cz_n = cz_reg + at;
        end
    end

    logic signed [33:0] c_v, s_v;
    always_comb
    begin
        unique case (quad_reg)
            2'd0:    begin c_v = cx_reg;  s_v = cy_reg;  end
            2'd1:    begin c_v = -cy_reg; s_v = cx_reg;  end
            2'd2:    begin c_v = -cx_reg; s_v = -cy_reg; end
            default: begin c_v = cy_reg;  s_v = -cx_reg; end
        endcase
    end

    // position sums and clipping
    logic signed [36:0] gx_full, gy_full;
    logic signed [37:0] sumx, sumy;
    logic [31:0] clx, cly;
    logic satx, saty;
    logic signed [65:0] th_sh;
    logic [31:0] hdg_n;
    always_comb
    begin
        gx_full = 37'(gx_acc_reg >>> 30);
        gy_full = 37'(gy_acc_reg >>> 30);
        sumx = 38'(signed'(pose_x_reg)) + 38'(gx_full);
        sumy = 38'(signed'(pose_y_reg)) + 38'(gy_full);
        satx = (sumx > 38'sh7FFF_FFFF) || (sumx < -38'sh8000_0000);
        saty = (sumy > 38'sh7FFF_FFFF) || (sumy < -38'sh8000_0000);
        clx = satx ? (sumx[37] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sumx[31:0];
        cly = saty ? (sumy[37] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sumy[31:0];
        // accumulator already holds the rounding offset
        th_sh = th_acc_reg >>> 36;
        hdg_n = pose_h_reg + th_sh[31:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_xfer && in_ch.op == podo_pkg::OP_INTEGRATE)
                    state_next = S_ROT;
            S_ROT:
                if (cnt_reg == CW'(NSTEPS))
                    state_next = S_PROD;
            S_PROD:
                state_next = S_SER;
            S_SER:
                if (phase_reg && bit_reg == 5'd16)
                    state_next = S_SUM;
            S_SUM:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            time_step_reg <= podo_pkg::TIME_STEP_RST;
            gain_reg      <= podo_pkg::GAIN_RST;
            pose_x_reg    <= '0;
            pose_y_reg    <= '0;
            pose_h_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                unique case (podo_pkg::reg_index_t'(cfg.index))
                    podo_pkg::REG_TIME_STEP: time_step_reg <= cfg.data;
                    podo_pkg::REG_GAIN:      gain_reg      <= cfg.data;
                    default: ;
                endcase
            end
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            if (in_xfer && in_ch.op == podo_pkg::OP_LOAD)
            begin
                pose_x_reg    <= in_ch.load_x;
                pose_y_reg    <= in_ch.load_y;
                pose_h_reg    <= in_ch.load_heading;
                out_valid_reg <= 1'b1;
            end
            if (state_reg == S_SUM && out_free)
            begin
                pose_x_reg    <= clx;
                pose_y_reg    <= cly;
                pose_h_reg    <= hdg_n;
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && in_ch.op == podo_pkg::OP_LOAD)
        begin
            out_x_reg   <= in_ch.load_x;
            out_y_reg   <= in_ch.load_y;
            out_h_reg   <= in_ch.load_heading;
            out_sat_reg <= 1'b0;
        end
        if (state_reg == S_SUM && out_free)
        begin
            out_x_reg   <= clx;
            out_y_reg   <= cly;
            out_h_reg   <= hdg_n;
            out_sat_reg <= satx || saty;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                vx_reg   <= signed'(in_ch.vel_x);
                vy_reg   <= signed'(in_ch.vel_y);
                wz_reg   <= signed'(in_ch.yaw_rate);
                quad_reg <= pose_h_reg[31:30] & ANGLE_MASK[31:30];
                cx_reg   <= 34'(podo_pkg::CORDIC_X0);
                cy_reg   <= '0;
                cz_reg   <= {2'b00, pose_h_reg[29:0] & ANGLE_MASK[29:0]};
                cnt_reg  <= '0;
            end
            S_ROT:
            begin
                if (cnt_reg != CW'(NSTEPS))
                begin
                    cx_reg  <= cx_n;
                    cy_reg  <= cy_n;
                    cz_reg  <= cz_n;
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            S_PROD:
            begin
                // 16x34 products, one register stage
                rx_reg     <= 51'(vx_reg * c_v) - 51'(vy_reg * s_v);
                ry_reg     <= 51'(vx_reg * s_v) + 51'(vy_reg * c_v);
                wprod_reg  <= 48'(wz_reg * signed'({1'b0, podo_pkg::INV_TWO_PI}));
                ts_sh_reg  <= time_step_reg;
                g_sh_reg   <= gain_reg;
                tx_acc_reg <= '0;
                ty_acc_reg <= '0;
                th_acc_reg <= 66'sh8_0000_0000;
                bit_reg    <= '0;
                phase_reg  <= 1'b0;
            end
            S_SER:
            begin
                // phase 0: times time_step; phase 1: times gain; one bit a cycle
                if (!phase_reg)
                begin
                    if (ts_sh_reg[0])
                    begin
                        tx_acc_reg <= tx_acc_reg + (68'(rx_reg) <<< bit_reg);
                        ty_acc_reg <= ty_acc_reg + (68'(ry_reg) <<< bit_reg);
                        th_acc_reg <= th_acc_reg + (66'(wprod_reg) <<< bit_reg);
                    end
                    ts_sh_reg <= ts_sh_reg >> 1;
                    bit_reg   <= bit_reg + 1'b1;
                    if (bit_reg == 5'd15)
                    begin
                        phase_reg <= 1'b1;
                        bit_reg   <= '0;
                        gx_acc_reg <= 67'sd536870912;
                        gy_acc_reg <= 67'sd536870912;
                    end
                end
                else
                begin
                    // bit 0 latches t, bits 1..16 take gain bits 0..15
                    if (bit_reg == 5'd0)
                    begin
                        tx_reg <= 36'(tx_acc_reg >>> 30);
                        ty_reg <= 36'(ty_acc_reg >>> 30);
                    end
                    else if (g_sh_reg[0])
                    begin
                        gx_acc_reg <= gx_acc_reg + (67'(tx_reg) <<< (bit_reg - 5'd1));
                        gy_acc_reg <= gy_acc_reg + (67'(ty_reg) <<< (bit_reg - 5'd1));
                    end
                    if (bit_reg != 5'd0)
                        g_sh_reg <= g_sh_reg >> 1;
                    bit_reg <= bit_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

>>> dv/podo_checker.sv
// Checker for the planar odometry integrator: watches the input, output and
// register-write channels, predicts each pose result and compares it.
// Depends on podo_pkg and the channel interfaces in podo_if.
module podo_checker
    import podo_pkg::*;
#(
    parameter int ANGLE_BITS   = 32,
    parameter int CORDIC_STEPS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    podo_in_if.sink    in_mon,
    podo_out_if.sink   out_mon,
    podo_cfg_if.sink   cfg_mon,
    output int         fail_count,
    output int         pending,
    output int         sat_seen,
    output int         results_seen
);

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] heading;
        logic        saturated;
    } pose_t;

    localparam longint ATAN_TBL [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    logic [15:0] step_reg;
    logic [15:0] gain_reg;
    logic [31:0] cur_x;
    logic [31:0] cur_y;
    logic [31:0] cur_hdg;
    pose_t       pose_q[$];

    function automatic void heading_trig(input logic [31:0] hdg,
                                         output longint c, output longint s);
        logic [31:0] a;
        longint x, y, z, nx, ny;
        a = hdg & ~((32'h1 << (32 - ANGLE_BITS)) - 32'h1);
        x = 652032874;
        y = 0;
        z = longint'(a[29:0]);
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= ATAN_TBL[i];
            end
            else
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += ATAN_TBL[i];
            end
            x = nx;
            y = ny;
        end
        case (a[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic longint world_delta(input longint rot);
        longint t;
        t = (rot * longint'(step_reg)) >>> 30;
        return (t * longint'(gain_reg) + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic [31:0] clip_pos(input longint v, inout logic sat);
        if (v > 64'sh7FFFFFFF)
        begin
            sat = 1'b1;
            return 32'h7FFFFFFF;
        end
        if (v < -64'sh80000000)
        begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pose_t  exp_p;
        pose_t  got;
        longint vx, vy, wz, c, s, dth;
        logic   sat;
        if (!rst_n)
        begin
            step_reg     = TIME_STEP_RST;
            gain_reg     = GAIN_RST;
            cur_x        = '0;
            cur_y        = '0;
            cur_hdg      = '0;
            fail_count   = 0;
            sat_seen     = 0;
            results_seen = 0;
            pose_q.delete();
        end
        else
        begin
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                if (cfg_mon.index == REG_TIME_STEP)
                    step_reg = cfg_mon.data;
                else if (cfg_mon.index == REG_GAIN)
                    gain_reg = cfg_mon.data;
            end
            if (out_mon.valid && out_mon.ready)
            begin
                got = '{out_mon.pos_x, out_mon.pos_y, out_mon.heading, out_mon.saturated};
                results_seen++;
                if (got.saturated)
                    sat_seen++;
                if (pose_q.size() == 0)
                begin
                    $error("unexpected result transfer");
                    fail_count++;
                end
                else
                begin
                    exp_p = pose_q.pop_front();
                    if (got.pos_x !== exp_p.pos_x)
                    begin
                        $error("pos_x exp %h got %h", exp_p.pos_x, got.pos_x);
                        fail_count++;
                    end
                    if (got.pos_y !== exp_p.pos_y)
                    begin
                        $error("pos_y exp %h got %h", exp_p.pos_y, got.pos_y);
                        fail_count++;
                    end
                    if (got.heading !== exp_p.heading)
                    begin
                        $error("heading exp %h got %h", exp_p.heading, got.heading);
                        fail_count++;
                    end
                    if (got.saturated !== exp_p.saturated)
                    begin
                        $error("saturated exp %b got %b", exp_p.saturated, got.saturated);
                        fail_count++;
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                sat = 1'b0;
                if (in_mon.op == OP_LOAD)
                begin
                    cur_x   = in_mon.load_x;
                    cur_y   = in_mon.load_y;
                    cur_hdg = in_mon.load_heading;
                end
                else
                begin
                    vx = longint'($signed(in_mon.vel_x));
                    vy = longint'($signed(in_mon.vel_y));
                    wz = longint'($signed(in_mon.yaw_rate));
                    heading_trig(cur_hdg, c, s);
                    cur_x = clip_pos(longint'($signed(cur_x))
                                     + world_delta(vx * c - vy * s), sat);
                    cur_y = clip_pos(longint'($signed(cur_y))
                                     + world_delta(vx * s + vy * c), sat);
                    dth = (wz * longint'(step_reg) * longint'(INV_TWO_PI)
                           + (64'sd1 <<< 35)) >>> 36;
                    cur_hdg = cur_hdg + dth[31:0];
                end
                pose_q.push_back('{cur_x, cur_y, cur_hdg, sat});
            end
        end
        pending = pose_q.size();
    end

endmodule

>>> dv/tb_planar_odometry_integrator.sv
// Top of the odometry integrator testbench: clock, reset, stimulus and verdict.
// Depends on podo_pkg, podo_if, podo_checker and the integrator RTL.
module tb_planar_odometry_integrator;
    import podo_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   sat_seen;
    int   results_seen;
    int   ticks_sent = 0;
    int   loads_sent = 0;
    bit   hold_off = 1'b0;

    podo_in_if  in_ch();
    podo_out_if out_ch();
    podo_cfg_if cfg();

    always #5 clk = ~clk;

    planar_odometry_integrator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    podo_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_mon       (in_ch),
        .out_mon      (out_ch),
        .cfg_mon      (cfg),
        .fail_count   (fail_count),
        .pending      (pending),
        .sat_seen     (sat_seen),
        .results_seen (results_seen)
    );

    initial
    begin
        in_ch.valid        = 1'b0;
        in_ch.op           = OP_INTEGRATE;
        in_ch.vel_x        = '0;
        in_ch.vel_y        = '0;
        in_ch.yaw_rate     = '0;
        in_ch.load_x       = '0;
        in_ch.load_y       = '0;
        in_ch.load_heading = '0;
        cfg.valid          = 1'b0;
        cfg.index          = REG_TIME_STEP;
        cfg.data           = '0;
        out_ch.ready       = 1'b0;
    end

    // Receiver: random stall pattern, plus a long hold-off on request.
    always @(posedge clk)
    begin
        int mode;
        mode = $urandom_range(0, 3);
        if (hold_off)
            out_ch.ready <= 1'b0;
        else if (mode == 0)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    // Offer one item; valid stays high if the next one follows directly.
    task automatic send_item(input op_t op, input logic [15:0] vx, input logic [15:0] vy,
                             input logic [15:0] wz, input logic [31:0] lx,
                             input logic [31:0] ly, input logic [31:0] lh);
        in_ch.valid        <= 1'b1;
        in_ch.op           <= op;
        in_ch.vel_x        <= vx;
        in_ch.vel_y        <= vy;
        in_ch.yaw_rate     <= wz;
        in_ch.load_x       <= lx;
        in_ch.load_y       <= ly;
        in_ch.load_heading <= lh;
        do @(posedge clk); while (!in_ch.ready);
        if (op == OP_LOAD)
            loads_sent++;
        else
            ticks_sent++;
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_tick();
        logic [15:0] vx, vy, wz;
        vx = 16'($urandom);
        vy = 16'($urandom);
        wz = 16'($urandom);
        if ($urandom_range(0, 3) != 0)
        begin
            vx = $signed(vx) >>> $urandom_range(0, 8);
            vy = $signed(vy) >>> $urandom_range(0, 8);
        end
        send_item(OP_INTEGRATE, vx, vy, wz, $urandom, $urandom, $urandom);
    endtask

    task automatic send_load();
        logic [31:0] lx, ly;
        lx = $urandom;
        ly = $urandom;
        // Often start near the edge so ticks clip.
        if ($urandom_range(0, 2) == 0)
        begin
            lx = {lx[31], {7{~lx[31]}}, lx[23:0]};
            ly = {ly[31], {7{~ly[31]}}, ly[23:0]};
        end
        send_item(OP_LOAD, 16'($urandom), 16'($urandom), 16'($urandom), lx, ly, $urandom);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic random_phase(input int n);
        int burst;
        int sent;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && sent < n; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_load();
                else
                    send_tick();
                sent++;
            end
            idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40));
        end
        drain();
    endtask

    initial
    begin
        logic [15:0] steps [5];
        logic [15:0] gains [5];
        steps = '{16'd16777, 16'd65535, 16'd0, 16'd1, 16'd40000};
        gains = '{16'd18022, 16'd65535, 16'd16384, 16'd0, 16'd1};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, both ops, quadrants, clipping on the lower rail.
        send_item(OP_INTEGRATE, 16'h7FFF, 16'h8000, 16'h7FFF, 0, 0, 0);
        send_item(OP_INTEGRATE, 16'h8000, 16'h7FFF, 16'h8000, 0, 0, 0);
        send_item(OP_INTEGRATE, 16'hFFFF, 16'h0001, 16'h0000, 0, 0, 0);
        send_item(OP_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h7FFFFFF0, 32'h80000010,
                  32'h40000000);
        send_item(OP_INTEGRATE, 16'h7FFF, 16'h7FFF, 16'h0000, 0, 0, 0);
        send_item(OP_INTEGRATE, 16'h8000, 16'h8000, 16'h0000, 0, 0, 0);
        send_item(OP_LOAD, 16'd0, 16'd0, 16'd0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        send_item(OP_INTEGRATE, 16'h7FFF, 16'h7FFF, 16'h0001, 0, 0, 0);
        send_item(OP_LOAD, 16'd0, 16'd0, 16'd0, 32'h00000000, 32'hFFFFFFFF, 32'hC0000000);
        send_item(OP_INTEGRATE, 16'h0100, 16'hFF00, 16'h1000, 0, 0, 0);
        send_item(OP_LOAD, 16'd0, 16'd0, 16'd0, 32'h12345678, 32'hEDCBA987, 32'hFFFFFFFF);
        send_item(OP_INTEGRATE, 16'h5555, 16'hAAAA, 16'h5555, 0, 0, 0);
        send_item(OP_INTEGRATE, 16'hAAAA, 16'h5555, 16'hAAAA, 0, 0, 0);
        drain();

        // Long output hold-off while the sender keeps offering.
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 12; k++)
                send_tick();
        join
        drain();

        for (int p = 0; p < 5; p++)
        begin
            write_reg(REG_TIME_STEP, steps[p]);
            write_reg(REG_GAIN, gains[p]);
            random_phase(p == 0 ? 250 : 95);
        end
        write_reg(REG_TIME_STEP, 16'($urandom));
        write_reg(REG_GAIN, 16'($urandom));
        random_phase(20);

        $display("Covered %0d ticks and %0d loads, %0d results, %0d saturated,",
                 ticks_sent, loads_sent, results_seen, sat_seen);
        $display("across six register settings including both extremes.");
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
